// ===== src/rfe_pkg.sv =====
package rfe_pkg;

  // Field and register widths
  localparam int DATA_W = 32;
  localparam int FRAC_W = 24;
  localparam int HR_W   = 26;
  localparam int IHR_W  = 31;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_HEAT_RATIO = 1'd0;
  localparam logic [IDX_W-1:0] REG_INV_GM1    = 1'd1;

  // Register reset values
  localparam logic [HR_W-1:0]  HR_RESET  = 26'd27962027;
  localparam logic [IHR_W-1:0] IHR_RESET = 31'd25165824;

  // Depth of the face queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Divider: 32 quotient bits, two per stage
  localparam int DIV_STAGES  = 16;
  // Square root: 28 root bits, two per stage
  localparam int ROOT_W      = 28;
  localparam int SQRT_STAGES = 14;

  // Flux values wait in a delay line from side stage 6 until the sound speed is ready
  localparam int MID_LEN  = DIV_STAGES + SQRT_STAGES - 3;
  // Register stages of the back part, from the face register to the result register
  localparam int BACK_LAT = MID_LEN + 10;

  typedef logic signed [DATA_W-1:0] word_t;

  // One face as it sits in the queue
  typedef struct packed {
    logic  op;
    logic  pos_l;
    logic  pos_r;
    word_t l_rho;
    word_t l_u;
    word_t l_v;
    word_t l_p;
    word_t r_rho;
    word_t r_u;
    word_t r_v;
    word_t r_p;
  } face_t;

  // Conserved state, normal flux and signal speed of one side
  typedef struct packed {
    logic              bad;
    logic [DATA_W:0]   s;
    word_t             u0;
    word_t             u1;
    word_t             u2;
    word_t             u3;
    word_t             f0;
    word_t             f1;
    word_t             f2;
    word_t             f3;
  } side_t;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
  localparam logic signed [65:0] ROUND_Q = 66'sd1 <<< (FRAC_W - 1);

  function automatic word_t sat_w(input logic signed [65:0] x);
    word_t r;
    if (x > SAT_MAX) begin
      r = word_t'(SAT_MAX[DATA_W-1:0]);
    end else if (x < SAT_MIN) begin
      r = word_t'(SAT_MIN[DATA_W-1:0]);
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // Q8.24 product, rounded half up, saturated
  function automatic word_t mulq(input word_t a, input word_t b);
    logic signed [63:0] pr;
    logic signed [65:0] t;
    pr = a * b;
    t  = 66'(pr) + ROUND_Q;
    return sat_w(t >>> FRAC_W);
  endfunction

endpackage

// ===== src/rfe_front.sv =====
module rfe_front #(
  parameter int DEPTH = rfe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  op,
  input  rfe_pkg::word_t        left_density,
  input  rfe_pkg::word_t        left_vel_x,
  input  rfe_pkg::word_t        left_vel_y,
  input  rfe_pkg::word_t        left_pressure,
  input  rfe_pkg::word_t        right_density,
  input  rfe_pkg::word_t        right_vel_x,
  input  rfe_pkg::word_t        right_vel_y,
  input  rfe_pkg::word_t        right_pressure,
  output logic                  full,
  output rfe_pkg::face_t        face,
  output logic                  avail,
  input  logic                  take
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rfe_pkg::face_t mem [DEPTH];
  rfe_pkg::face_t wr_face;
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  count;
  logic           wr;
  logic           rd;

  // Classify each side by the sign of its density
  always_comb begin
    wr_face.op    = op;
    wr_face.pos_l = left_density > 0;
    wr_face.pos_r = right_density > 0;
    wr_face.l_rho = left_density;
    wr_face.l_u   = left_vel_x;
    wr_face.l_v   = left_vel_y;
    wr_face.l_p   = left_pressure;
    wr_face.r_rho = right_density;
    wr_face.r_u   = right_vel_x;
    wr_face.r_v   = right_vel_y;
    wr_face.r_p   = right_pressure;
  end

  assign full  = count == CW'(DEPTH);
  assign avail = count != '0;
  assign wr    = push && !full;
  assign rd    = take && avail;
  assign face  = mem[rp];

  // Store the word
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_face;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rfe_div.sv =====
module rfe_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          ok,
  input  rfe_pkg::word_t                g,
  input  rfe_pkg::word_t                rho,
  output logic [rfe_pkg::DATA_W-2:0]    q
);

  localparam int N = rfe_pkg::DIV_STAGES;

  typedef struct packed {
    logic        ok;
    logic        sat;
    logic [30:0] d;
    logic [30:0] rem;
    logic [31:0] num;
    logic [31:0] q;
  } dv_t;

  function automatic dv_t dv_step(input dv_t a);
    dv_t         o;
    logic [31:0] t;
    logic [31:0] diff;
    o    = a;
    t    = {a.rem, a.num[31]};
    diff = t - {1'b0, a.d};
    o.num = {a.num[30:0], 1'b0};
    if (t >= {1'b0, a.d}) begin
      o.rem = diff[30:0];
      o.q   = {a.q[30:0], 1'b1};
    end else begin
      o.rem = t[30:0];
      o.q   = {a.q[30:0], 1'b0};
    end
    return o;
  endfunction

  dv_t pre;
  dv_t st [N];

  // Load remainder with g/256 and flag a quotient that clips
  always_ff @(posedge clk) begin
    if (en) begin
      pre.ok  <= ok;
      pre.sat <= 38'(g[30:0]) >= {rho[30:0], 7'b0};
      pre.d   <= rho[30:0];
      pre.rem <= {7'b0, g[31:8]};
      pre.num <= {g[7:0], 24'b0};
      pre.q   <= '0;
    end
  end

  // Two quotient bits per stage
  for (genvar k = 0; k < N; k++) begin : g_st
    dv_t a;
    dv_t b;
    if (k == 0) begin : g_first
      assign a = pre;
    end else begin : g_rest
      assign a = st[k-1];
    end
    always_comb begin
      b = dv_step(dv_step(a));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= b;
      end
    end
  end

  assign q = !st[N-1].ok ? '0 : st[N-1].sat ? 31'h7FFFFFFF : st[N-1].q[30:0];

endmodule

// ===== src/rfe_sqrt.sv =====
module rfe_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rfe_pkg::DATA_W-2:0]    q,
  output logic [rfe_pkg::ROOT_W-1:0]    root
);

  localparam int N  = rfe_pkg::SQRT_STAGES;
  localparam int RW = rfe_pkg::ROOT_W;
  localparam int XW = 2 * RW;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [31:0]   rem;
    logic [RW-1:0] root;
  } sq_t;

  function automatic sq_t sq_step(input sq_t a);
    sq_t         o;
    logic [31:0] t;
    logic [31:0] trial;
    t     = {a.rem[29:0], a.x[XW-1:XW-2]};
    trial = 32'({a.root, 2'b01});
    o.x   = {a.x[XW-3:0], 2'b00};
    if (t >= trial) begin
      o.rem  = t - trial;
      o.root = {a.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = t;
      o.root = {a.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  sq_t init;
  sq_t st [N];

  // Radicand is q scaled by 2^24
  always_comb begin
    init.x    = XW'({q, 24'b0});
    init.rem  = '0;
    init.root = '0;
  end

  // Two root bits per stage
  for (genvar k = 0; k < N; k++) begin : g_st
    sq_t a;
    sq_t b;
    if (k == 0) begin : g_first
      assign a = init;
    end else begin : g_rest
      assign a = st[k-1];
    end
    always_comb begin
      b = sq_step(sq_step(a));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= b;
      end
    end
  end

  assign root = st[N-1].root;

endmodule

// ===== src/rfe_side.sv =====
module rfe_side (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rfe_pkg::HR_W-1:0]    heat_ratio,
  input  logic [rfe_pkg::IHR_W-1:0]   inv_heat_ratio_less_one,
  input  logic                        op,
  input  logic                        pos,
  input  rfe_pkg::word_t              rho,
  input  rfe_pkg::word_t              u,
  input  rfe_pkg::word_t              v,
  input  rfe_pkg::word_t              p,
  output rfe_pkg::side_t              res
);

  localparam int L = rfe_pkg::MID_LEN;

  typedef struct packed {
    logic                       bad;
    logic [rfe_pkg::DATA_W-1:0] absn;
    rfe_pkg::word_t             u0;
    rfe_pkg::word_t             u1;
    rfe_pkg::word_t             u2;
    rfe_pkg::word_t             u3;
    rfe_pkg::word_t             f0;
    rfe_pkg::word_t             f1;
    rfe_pkg::word_t             f2;
    rfe_pkg::word_t             f3;
  } mid_t;

  logic s1_op, s2_op, s3_op, s4_op, s5_op;
  logic s1_pos, s2_pos, s3_pos, s4_pos, s5_pos;
  rfe_pkg::word_t s1_rho, s2_rho, s3_rho, s4_rho, s5_rho;
  rfe_pkg::word_t s1_p, s2_p, s3_p, s4_p;
  rfe_pkg::word_t s1_n, s2_n, s3_n, s4_n, s5_n;
  rfe_pkg::word_t s1_mx, s2_mx, s3_mx, s4_mx, s5_mx;
  rfe_pkg::word_t s1_my, s2_my, s3_my, s4_my, s5_my;
  rfe_pkg::word_t s1_uu, s1_vv, s1_pi, s1_g;
  rfe_pkg::word_t s2_ke2, s2_fxn, s2_fyn, s2_pi;
  rfe_pkg::word_t s3_rke, s3_fmx, s3_fmy, s3_pi;
  rfe_pkg::word_t s4_e, s4_fmx, s4_fmy;
  rfe_pkg::word_t s5_e, s5_ep, s5_fmx, s5_fmy;
  logic [rfe_pkg::DATA_W-2:0] q;
  logic [rfe_pkg::ROOT_W-1:0] root;
  mid_t mid;
  mid_t dl [L];

  // Stage 1: momenta, squared velocities, internal energy, gamma*p
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= op;
      s1_pos <= pos;
      s1_rho <= rho;
      s1_p   <= p;
      s1_n   <= op ? v : u;
      s1_mx  <= rfe_pkg::mulq(rho, u);
      s1_my  <= rfe_pkg::mulq(rho, v);
      s1_uu  <= rfe_pkg::mulq(u, u);
      s1_vv  <= rfe_pkg::mulq(v, v);
      s1_pi  <= rfe_pkg::mulq(p, $signed({1'b0, inv_heat_ratio_less_one}));
      s1_g   <= rfe_pkg::mulq($signed({6'b0, heat_ratio}), p);
    end
  end

  // Stage 2: kinetic term sum, momentum times normal velocity
  always_ff @(posedge clk) begin
    if (en) begin
      s2_op  <= s1_op;
      s2_pos <= s1_pos;
      s2_rho <= s1_rho;
      s2_p   <= s1_p;
      s2_n   <= s1_n;
      s2_mx  <= s1_mx;
      s2_my  <= s1_my;
      s2_pi  <= s1_pi;
      s2_ke2 <= rfe_pkg::sat_w(66'(s1_uu) + 66'(s1_vv));
      s2_fxn <= rfe_pkg::mulq(s1_mx, s1_n);
      s2_fyn <= rfe_pkg::mulq(s1_my, s1_n);
    end
  end

  // Stage 3: density times kinetic term, add pressure to the normal momentum flux
  always_ff @(posedge clk) begin
    if (en) begin
      s3_op  <= s2_op;
      s3_pos <= s2_pos;
      s3_rho <= s2_rho;
      s3_p   <= s2_p;
      s3_n   <= s2_n;
      s3_mx  <= s2_mx;
      s3_my  <= s2_my;
      s3_pi  <= s2_pi;
      s3_rke <= rfe_pkg::mulq(s2_rho, s2_ke2);
      s3_fmx <= rfe_pkg::sat_w(66'(s2_fxn) + (s2_op ? 66'sd0 : 66'(s2_p)));
      s3_fmy <= rfe_pkg::sat_w(66'(s2_fyn) + (s2_op ? 66'(s2_p) : 66'sd0));
    end
  end

  // Stage 4: total energy
  always_ff @(posedge clk) begin
    if (en) begin
      s4_op  <= s3_op;
      s4_pos <= s3_pos;
      s4_rho <= s3_rho;
      s4_p   <= s3_p;
      s4_n   <= s3_n;
      s4_mx  <= s3_mx;
      s4_my  <= s3_my;
      s4_fmx <= s3_fmx;
      s4_fmy <= s3_fmy;
      s4_e   <= rfe_pkg::sat_w(66'(s3_pi) + ((66'(s3_rke) + 66'sd1) >>> 1));
    end
  end

  // Stage 5: energy plus pressure
  always_ff @(posedge clk) begin
    if (en) begin
      s5_op  <= s4_op;
      s5_pos <= s4_pos;
      s5_rho <= s4_rho;
      s5_n   <= s4_n;
      s5_mx  <= s4_mx;
      s5_my  <= s4_my;
      s5_fmx <= s4_fmx;
      s5_fmy <= s4_fmy;
      s5_e   <= s4_e;
      s5_ep  <= rfe_pkg::sat_w(66'(s4_e) + 66'(s4_p));
    end
  end

  // Stage 6: energy flux and packing
  always_comb begin
    mid.bad  = !s5_pos;
    mid.absn = s5_n[rfe_pkg::DATA_W-1] ? rfe_pkg::DATA_W'(-s5_n) : rfe_pkg::DATA_W'(s5_n);
    mid.u0   = s5_rho;
    mid.u1   = s5_mx;
    mid.u2   = s5_my;
    mid.u3   = s5_e;
    mid.f0   = s5_op ? s5_my : s5_mx;
    mid.f1   = s5_fmx;
    mid.f2   = s5_fmy;
    mid.f3   = rfe_pkg::mulq(s5_ep, s5_n);
  end

  // Hold flux values until the sound speed arrives
  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= mid;
      for (int i = 1; i < L; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // Sound speed: sqrt(gamma*p/rho), zero for a non-positive side or gamma*p
  rfe_div u_div (
    .clk (clk),
    .en  (en),
    .ok  (s1_pos && (s1_g > 0)),
    .g   (s1_g),
    .rho (s1_rho),
    .q   (q)
  );

  rfe_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .q    (q),
    .root (root)
  );

  // Signal speed and side result
  always_ff @(posedge clk) begin
    if (en) begin
      res.bad <= dl[L-1].bad;
      res.s   <= (rfe_pkg::DATA_W + 1)'(dl[L-1].absn) + (rfe_pkg::DATA_W + 1)'(root);
      res.u0  <= dl[L-1].u0;
      res.u1  <= dl[L-1].u1;
      res.u2  <= dl[L-1].u2;
      res.u3  <= dl[L-1].u3;
      res.f0  <= dl[L-1].f0;
      res.f1  <= dl[L-1].f1;
      res.f2  <= dl[L-1].f2;
      res.f3  <= dl[L-1].f3;
    end
  end

endmodule

// ===== src/rfe_back.sv =====
module rfe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rfe_pkg::HR_W-1:0]    heat_ratio,
  input  logic [rfe_pkg::IHR_W-1:0]   inv_heat_ratio_less_one,
  input  rfe_pkg::face_t              face,
  input  logic                        avail,
  output logic                        take,
  input  logic                        pop,
  output logic                        out_valid,
  output rfe_pkg::word_t              flux_mass,
  output rfe_pkg::word_t              flux_mom_x,
  output rfe_pkg::word_t              flux_mom_y,
  output rfe_pkg::word_t              flux_energy,
  output logic                        bad_state
);

  localparam int LAT = rfe_pkg::BACK_LAT;

  logic [LAT-1:0] vld;
  logic           en;
  rfe_pkg::face_t f0;
  rfe_pkg::side_t sl;
  rfe_pkg::side_t sr;

  logic [rfe_pkg::DATA_W:0]   smax_raw;
  logic [rfe_pkg::DATA_W-2:0] c1_smax;
  logic                       c1_bad, c2_bad;
  rfe_pkg::word_t             ul [4];
  rfe_pkg::word_t             ur [4];
  rfe_pkg::word_t             fl [4];
  rfe_pkg::word_t             fr [4];
  rfe_pkg::word_t             c1_d [4];
  logic signed [32:0]         c1_fs [4];
  logic signed [32:0]         c2_fs [4];
  logic signed [63:0]         c2_pr [4];
  logic signed [65:0]         num [4];
  rfe_pkg::word_t             res [4];

  // The whole back part moves while the result register is free or being taken
  assign en        = !vld[LAT-1] || pop;
  assign take      = en && avail;
  assign out_valid = vld[LAT-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], avail};
    end
  end

  // Face register
  always_ff @(posedge clk) begin
    if (en) begin
      f0 <= face;
    end
  end

  rfe_side u_left (
    .clk                     (clk),
    .en                      (en),
    .heat_ratio              (heat_ratio),
    .inv_heat_ratio_less_one (inv_heat_ratio_less_one),
    .op                      (f0.op),
    .pos                     (f0.pos_l),
    .rho                     (f0.l_rho),
    .u                       (f0.l_u),
    .v                       (f0.l_v),
    .p                       (f0.l_p),
    .res                     (sl)
  );

  rfe_side u_right (
    .clk                     (clk),
    .en                      (en),
    .heat_ratio              (heat_ratio),
    .inv_heat_ratio_less_one (inv_heat_ratio_less_one),
    .op                      (f0.op),
    .pos                     (f0.pos_r),
    .rho                     (f0.r_rho),
    .u                       (f0.r_u),
    .v                       (f0.r_v),
    .p                       (f0.r_p),
    .res                     (sr)
  );

  always_comb begin
    ul[0] = sl.u0; ul[1] = sl.u1; ul[2] = sl.u2; ul[3] = sl.u3;
    ur[0] = sr.u0; ur[1] = sr.u1; ur[2] = sr.u2; ur[3] = sr.u3;
    fl[0] = sl.f0; fl[1] = sl.f1; fl[2] = sl.f2; fl[3] = sl.f3;
    fr[0] = sr.f0; fr[1] = sr.f1; fr[2] = sr.f2; fr[3] = sr.f3;
    smax_raw = (sl.s > sr.s) ? sl.s : sr.s;
  end

  // Combine 1: clipped largest speed, state jump, flux sum
  always_ff @(posedge clk) begin
    if (en) begin
      c1_smax <= (smax_raw > 33'h07FFFFFFF) ? 31'h7FFFFFFF : smax_raw[rfe_pkg::DATA_W-2:0];
      c1_bad  <= sl.bad | sr.bad;
      for (int k = 0; k < 4; k++) begin
        c1_d[k]  <= rfe_pkg::sat_w(66'(ur[k]) - 66'(ul[k]));
        c1_fs[k] <= 33'(fl[k]) + 33'(fr[k]);
      end
    end
  end

  // Combine 2: speed times jump
  always_ff @(posedge clk) begin
    if (en) begin
      c2_bad <= c1_bad;
      for (int k = 0; k < 4; k++) begin
        c2_fs[k] <= c1_fs[k];
        c2_pr[k] <= $signed({1'b0, c1_smax}) * c1_d[k];
      end
    end
  end

  // Combine 3: subtract, halve with rounding, saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num[k] = (66'(c2_fs[k]) <<< rfe_pkg::FRAC_W) - 66'(c2_pr[k]);
      res[k] = rfe_pkg::sat_w((num[k] + (66'sd1 <<< rfe_pkg::FRAC_W)) >>> (rfe_pkg::FRAC_W + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flux_mass   <= res[0];
      flux_mom_x  <= res[1];
      flux_mom_y  <= res[2];
      flux_energy <= res[3];
      bad_state   <= c2_bad;
    end
  end

endmodule

// ===== src/rusanov_flux_euler_2d_core.sv =====
// Faces pass the queue, face register, side and combine stages and the result register.
// Throughput: one face per cycle; the divider and square root are fully pipelined
// (two bits per stage), and the whole back pipeline holds only while a finished word waits.
// Reset (rst, synchronous, active high) empties the face queue and the pipeline and
// loads heat_ratio with 5/3 and inv_heat_ratio_less_one with 1.5.
module rusanov_flux_euler_2d_core #(
  parameter int QUEUE_DEPTH = rfe_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [rfe_pkg::IDX_W-1:0]   wr_index,
  input  logic [rfe_pkg::CFG_W-1:0]   wr_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        op,
  input  rfe_pkg::word_t              left_density,
  input  rfe_pkg::word_t              left_vel_x,
  input  rfe_pkg::word_t              left_vel_y,
  input  rfe_pkg::word_t              left_pressure,
  input  rfe_pkg::word_t              right_density,
  input  rfe_pkg::word_t              right_vel_x,
  input  rfe_pkg::word_t              right_vel_y,
  input  rfe_pkg::word_t              right_pressure,
  output logic                        empty,
  input  logic                        pop,
  output rfe_pkg::word_t              flux_mass,
  output rfe_pkg::word_t              flux_mom_x,
  output rfe_pkg::word_t              flux_mom_y,
  output rfe_pkg::word_t              flux_energy,
  output logic                        bad_state
);

  logic [rfe_pkg::HR_W-1:0]  heat_ratio;
  logic [rfe_pkg::IHR_W-1:0] inv_heat_ratio_less_one;
  rfe_pkg::face_t            face;
  logic                      avail;
  logic                      take;
  logic                      out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heat_ratio              <= rfe_pkg::HR_RESET;
      inv_heat_ratio_less_one <= rfe_pkg::IHR_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        rfe_pkg::REG_HEAT_RATIO: heat_ratio <= wr_data[rfe_pkg::HR_W-1:0];
        rfe_pkg::REG_INV_GM1:    inv_heat_ratio_less_one <= wr_data;
        default: ;
      endcase
    end
  end

  rfe_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .op             (op),
    .left_density   (left_density),
    .left_vel_x     (left_vel_x),
    .left_vel_y     (left_vel_y),
    .left_pressure  (left_pressure),
    .right_density  (right_density),
    .right_vel_x    (right_vel_x),
    .right_vel_y    (right_vel_y),
    .right_pressure (right_pressure),
    .full           (full),
    .face           (face),
    .avail          (avail),
    .take           (take)
  );

  rfe_back u_back (
    .clk                     (clk),
    .rst                     (rst),
    .heat_ratio              (heat_ratio),
    .inv_heat_ratio_less_one (inv_heat_ratio_less_one),
    .face                    (face),
    .avail                   (avail),
    .take                    (take),
    .pop                     (pop),
    .out_valid               (out_valid),
    .flux_mass               (flux_mass),
    .flux_mom_x              (flux_mom_x),
    .flux_mom_y              (flux_mom_y),
    .flux_energy             (flux_energy),
    .bad_state               (bad_state)
  );

  assign empty = !out_valid;

endmodule
